FILE: rtl/core/rfpdl_pkg.sv
// Package for the receive frame parser with device learning.
// Holds phase, status and frame-layout constants; no dependencies.
package rfpdl_pkg;
    localparam logic [7:0] DELIM       = 8'h7E;
    localparam logic [7:0] RX_PACKET   = 8'h90;
    localparam logic [7:0] ANY_CHANNEL = 8'hFF;
    localparam int         HEADER_BYTES = 15;

    typedef enum logic [1:0] {
        ST_MATCH   = 2'd0,
        ST_LEARNED = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [5:0] {
        PH_HUNT    = 6'b000001,
        PH_LEN_MSB = 6'b000010,
        PH_LEN_LSB = 6'b000100,
        PH_COLLECT = 6'b001000,
        PH_SEARCH  = 6'b010000,
        PH_EMIT    = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [63:0] addr;
        logic [7:0]  wired;
        logic [7:0]  kind;
    } key_t;
endpackage

FILE: rtl/core/rfpdl_stream_if.sv
// Valid/ready stream interfaces for input and result transactions.
// Depends on nothing.
interface rfpdl_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;
    modport source (output valid, op, rx_byte, input ready);
    modport sink (input valid, op, rx_byte, output ready);
endinterface

interface rfpdl_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
    modport source (output valid, out_byte, out_last, status, input ready);
    modport sink (input valid, out_byte, out_last, status, output ready);
endinterface

FILE: rtl/core/rfpdl_entry_cell.sv
// One device table cell: holds an entry and compares it with the key.
// Passes the key and running match results to the next cell. Uses rfpdl_pkg.
module rfpdl_entry_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  rfpdl_pkg::key_t   wr_key,
    input  logic [7:0]        wr_net,
    input  logic              used,
    input  rfpdl_pkg::key_t   key_in,
    input  logic              hit_in,
    input  logic              net_in_found,
    input  logic [7:0]        net_in,
    output rfpdl_pkg::key_t   key_out,
    output logic              hit_out,
    output logic              net_out_found,
    output logic [7:0]        net_out,
    output logic              hit_here
);
    import rfpdl_pkg::*;
    key_t       key_reg;
    logic [7:0] net_reg;
    key_t       ent_reg;
    logic [7:0] ent_net_reg;
    logic       hit_reg;
    logic       nf_reg;
    logic       hh_reg;
    logic       addr_eq;
    logic       full_eq;

    assign addr_eq = used && !hit_in && (ent_reg.addr == key_in.addr);
    assign full_eq = addr_eq && ent_reg.wired == key_in.wired && ent_reg.kind == key_in.kind;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg     <= wr_key;
            ent_net_reg <= wr_net;
        end
        key_reg <= key_in;
        net_reg <= addr_eq ? ent_net_reg : net_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
            nf_reg  <= 1'b0;
            hh_reg  <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_in || full_eq;
            nf_reg  <= net_in_found || addr_eq;
            hh_reg  <= full_eq;
        end
    end

    assign key_out       = key_reg;
    assign hit_out       = hit_reg;
    assign net_out_found = nf_reg;
    assign net_out       = net_reg;
    assign hit_here      = hh_reg;
endmodule

FILE: rtl/core/rx_frame_parse_device_learn_core.sv
// Receive frame parser with device learning: top level.
// After the last frame byte, the key is searched through the cell chain; the result bytes
// then follow at one per cycle while the output side is ready.
// Throughput: one byte per cycle; no byte is taken during search or emission.
// Reset clears phase, counters and table fill; table and frame contents are unset.
module rx_frame_parse_device_learn_core #(
    parameter int TABLE_ENTRIES = 16,
    parameter int FRAME_BYTES   = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    rfpdl_in_if.sink    in_ch,
    rfpdl_out_if.source out_ch
);
    import rfpdl_pkg::*;
    localparam int PW = $clog2(FRAME_BYTES + 1);
    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int CW = $clog2(TABLE_ENTRIES + 3);

    logic [7:0]  own_reg;
    phase_t      phase_reg;
    logic [7:0]  len_reg;
    logic [PW-1:0] pos_reg;
    logic [7:0]  mem [FRAME_BYTES];
    logic [7:0]  key_b [15];
    logic [UW-1:0] used_reg;
    logic [7:0]  nets_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] rd_reg;
    logic [7:0]  rd_data;
    logic [1:0]  st_reg;
    logic [7:0]  idx_reg;
    logic        first_reg;
    logic        ov_reg;
    logic        last_reg;
    logic [7:0]  ob_reg;
    logic [1:0]  os_reg;

    key_t        key_c [TABLE_ENTRIES+1];
    logic        hit_c [TABLE_ENTRIES+1];
    logic        nf_c  [TABLE_ENTRIES+1];
    logic [7:0]  net_c [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] hh;
    logic [TABLE_ENTRIES-1:0] hh_reg;
    logic [IW-1:0] hit_idx;
    key_t        fkey;
    logic        acc;
    logic        pass;
    logic        emit_go;

    always_comb
    begin
        fkey.addr  = {key_b[1], key_b[2], key_b[3], key_b[4], key_b[5], key_b[6],
                      key_b[7], key_b[8]};
        fkey.wired = key_b[12];
        fkey.kind  = key_b[14];
    end

    assign key_c[0] = fkey;
    assign hit_c[0] = 1'b0;
    assign nf_c[0]  = 1'b0;
    assign net_c[0] = 8'd0;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            rfpdl_entry_cell u_cell (
                .clk(clk), .rst_n(rst_n),
                .wr_en(phase_reg == PH_SEARCH && cnt_reg == CW'(TABLE_ENTRIES + 1)
                       && !hit_c[TABLE_ENTRIES] && used_reg == UW'(g)),
                .wr_key(fkey),
                .wr_net(nf_c[TABLE_ENTRIES] ? net_c[TABLE_ENTRIES] : nets_reg + 8'd1),
                .used(used_reg > UW'(g)),
                .key_in(key_c[g]), .hit_in(hit_c[g]), .net_in_found(nf_c[g]),
                .net_in(net_c[g]),
                .key_out(key_c[g+1]), .hit_out(hit_c[g+1]),
                .net_out_found(nf_c[g+1]), .net_out(net_c[g+1]),
                .hit_here(hh[g])
            );
        end
    endgenerate

    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (hh_reg[k])
                hit_idx = IW'(k);
        end
    end

    assign acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (phase_reg == PH_HUNT || phase_reg == PH_LEN_MSB
                         || phase_reg == PH_LEN_LSB || phase_reg == PH_COLLECT);
    assign pass = key_b[0] == RX_PACKET && len_reg >= 8'(HEADER_BYTES) &&
                  (key_b[13] == own_reg || key_b[13] == ANY_CHANNEL ||
                   key_b[13] == 8'd0 || own_reg == ANY_CHANNEL);
    assign emit_go = !ov_reg || out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (acc && !in_ch.op && phase_reg == PH_COLLECT)
        begin
            if (pos_reg < PW'(FRAME_BYTES))
                mem[pos_reg[PW-1:0]] <= in_ch.rx_byte;
        end
        if (phase_reg != PH_EMIT || emit_go)
            rd_data <= mem[rd_reg];
    end

    always_ff @(posedge clk)
    begin
        if (acc && !in_ch.op && phase_reg == PH_COLLECT && pos_reg < PW'(HEADER_BYTES))
            key_b[pos_reg[3:0]] <= in_ch.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_reg   <= 8'd0;
            phase_reg <= PH_HUNT;
            len_reg   <= 8'd0;
            pos_reg   <= '0;
            used_reg  <= '0;
            nets_reg  <= 8'd1;
            cnt_reg   <= '0;
            rd_reg    <= '0;
            st_reg    <= ST_MATCH;
            idx_reg   <= 8'd0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
            last_reg  <= 1'b0;
            ob_reg    <= 8'd0;
            os_reg    <= 2'd0;
            hh_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
                own_reg <= cfg_wdata;
            if (out_ch.ready && !(phase_reg == PH_EMIT && emit_go))
                ov_reg <= 1'b0;
            hh_reg <= hh;
            case (phase_reg)
                PH_HUNT:
                begin
                    if (acc && !in_ch.op && in_ch.rx_byte == DELIM)
                        phase_reg <= PH_LEN_MSB;
                end
                PH_LEN_MSB:
                begin
                    if (acc)
                        phase_reg <= in_ch.op ? PH_HUNT : PH_LEN_LSB;
                end
                PH_LEN_LSB:
                begin
                    if (acc)
                    begin
                        if (in_ch.op || in_ch.rx_byte == 8'd0
                            || in_ch.rx_byte > 8'(FRAME_BYTES))
                            phase_reg <= PH_HUNT;
                        else
                        begin
                            len_reg   <= in_ch.rx_byte;
                            pos_reg   <= '0;
                            phase_reg <= PH_COLLECT;
                        end
                    end
                end
                PH_COLLECT:
                begin
                    if (acc)
                    begin
                        if (in_ch.op)
                            phase_reg <= PH_HUNT;
                        else if (8'(pos_reg) + 8'd1 == len_reg)
                        begin
                            cnt_reg   <= '0;
                            phase_reg <= PH_SEARCH;
                        end
                        else
                            pos_reg <= pos_reg + PW'(1);
                    end
                end
                PH_SEARCH:
                begin
                    if (!pass)
                        phase_reg <= PH_HUNT;
                    else if (cnt_reg != CW'(TABLE_ENTRIES + 1))
                        cnt_reg <= cnt_reg + CW'(1);
                    else
                    begin
                        first_reg <= 1'b1;
                        rd_reg    <= PW'(HEADER_BYTES);
                        phase_reg <= PH_EMIT;
                        if (hit_c[TABLE_ENTRIES])
                        begin
                            st_reg  <= ST_MATCH;
                            idx_reg <= 8'(hit_idx);
                        end
                        else if (used_reg == UW'(TABLE_ENTRIES))
                        begin
                            st_reg  <= ST_FULL;
                            idx_reg <= 8'd0;
                        end
                        else
                        begin
                            st_reg   <= ST_LEARNED;
                            idx_reg  <= 8'(used_reg);
                            used_reg <= used_reg + UW'(1);
                            if (!nf_c[TABLE_ENTRIES])
                                nets_reg <= nets_reg + 8'd1;
                        end
                    end
                end
                PH_EMIT:
                begin
                    if (emit_go)
                    begin
                        ov_reg <= 1'b1;
                        os_reg <= st_reg;
                        if (first_reg)
                        begin
                            first_reg <= 1'b0;
                            ob_reg    <= idx_reg;
                            last_reg  <= st_reg == ST_FULL || len_reg == 8'(HEADER_BYTES);
                            rd_reg    <= rd_reg + PW'(1);
                            if (st_reg == ST_FULL || len_reg == 8'(HEADER_BYTES))
                                phase_reg <= PH_HUNT;
                        end
                        else
                        begin
                            ob_reg   <= rd_data;
                            last_reg <= 8'(rd_reg) == len_reg;
                            rd_reg   <= rd_reg + PW'(1);
                            if (8'(rd_reg) == len_reg)
                                phase_reg <= PH_HUNT;
                        end
                    end
                end
                default:
                    phase_reg <= PH_HUNT;
            endcase
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.out_byte = ob_reg;
    assign out_ch.out_last = last_reg;
    assign out_ch.status   = os_reg;
endmodule

FILE: rtl/core/rfpdl_checker.sv
// Port-level checker for the receive frame parser, bound to the top level.
// Depends on the stream interfaces of the top level's ports.
module rfpdl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_last,
    input logic [1:0] status
);
    a_full_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == 2'd2 |-> out_last) else $error("full without last");
    a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready) else $error("input during message");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("valid dropped");
endmodule

bind rx_frame_parse_device_learn_core rfpdl_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.out_last), .status(out_ch.status)
);
